### src/cslfo_pkg.sv
// cslfo_pkg: shared types, field widths, reset constants and the cosine
// series helper used to build the waveform table of the clock-synced dual lfo
// no dependencies
`default_nettype none

package cslfo_pkg;

	localparam int SINE_TABLE_DEPTH_DEF = 256;
	localparam int OUTPUT_BITS_DEF      = 16;
	localparam int MAX_MULTIPLIER_DEF   = 16;

	localparam int KNOB_W  = 13;
	localparam int JACK_W  = 14;
	localparam int CTL_W   = 13;
	localparam int PHASE_W = 32;

	localparam logic [CTL_W-1:0]   CTL_FULL  = 13'd4096;
	localparam logic [PHASE_W-1:0] INC_RESET = 32'd429497;
	localparam logic [PHASE_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

	// shape select thresholds on 49*t
	localparam int SHP_PROD_W = 18;
	localparam logic [SHP_PROD_W-1:0] SHP_MUL  = 18'd49;
	localparam logic [SHP_PROD_W-1:0] SHP_TH1  = 18'd40960;
	localparam logic [SHP_PROD_W-1:0] SHP_TH2  = 18'd81920;
	localparam logic [SHP_PROD_W-1:0] SHP_TH3  = 18'd122880;
	localparam logic [SHP_PROD_W-1:0] SHP_TH4  = 18'd163840;

	localparam longint PI_Q30  = 64'sd3373259426;
	localparam longint ONE_Q30 = 64'sd1073741824;

	typedef enum logic [2:0] {
		SHP_TRIANGLE,
		SHP_REV_RAMP,
		SHP_SQUARE,
		SHP_COSINE,
		SHP_RAMP
	} shape_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_PREP,
		ST_DIV_START,
		ST_DIV,
		ST_DIV_END,
		ST_UPDATE,
		ST_INDEX,
		ST_ROM,
		ST_SHAPE,
		ST_FIN
	} state_t;

	// cos(x) in q30 for x in [0, pi/2] in q30, taylor series through x^12
	function automatic longint cos_q30(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] term;
		longint      sum;
		x2   = (x * x) >> 30;
		term = 64'(ONE_Q30);
		sum  = ONE_Q30;
		for (int n = 1; n <= 6; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
			if (n[0]) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		return sum;
	endfunction

	// knob clamped to 0..4096, jack to -4096..4096, sum to 0..4096
	function automatic logic [CTL_W-1:0] control_t(input logic [KNOB_W-1:0] knob,
			input logic signed [JACK_W-1:0] jack);
		logic [KNOB_W-1:0]        k;
		logic signed [JACK_W-1:0] j;
		logic signed [JACK_W:0]   s;
		k = (knob > CTL_FULL) ? CTL_FULL : knob;
		if (jack > 14'sd4096) begin
			j = 14'sd4096;
		end else if (jack < -14'sd4096) begin
			j = -14'sd4096;
		end else begin
			j = jack;
		end
		s = $signed({2'b00, k}) + (JACK_W + 1)'(j);
		if (s < 0) begin
			return '0;
		end else if (s > $signed({2'b00, CTL_FULL})) begin
			return CTL_FULL;
		end else begin
			return s[CTL_W-1:0];
		end
	endfunction

endpackage

`default_nettype wire

### src/cslfo_if.sv
// cslfo_in_if / cslfo_out_if: valid-ready channels for tick items and results
// depends on cslfo_pkg for field widths
`default_nettype none

interface cslfo_in_if;
	import cslfo_pkg::*;

	logic                     valid;
	logic                     ready;
	logic                     clock_trig_a;
	logic                     clock_trig_b;
	logic                     reset_pulse;
	logic                     led_select;
	logic [KNOB_W-1:0]        knob_rate_a;
	logic signed [JACK_W-1:0] jack_rate_a;
	logic [KNOB_W-1:0]        knob_rate_b;
	logic signed [JACK_W-1:0] jack_rate_b;
	logic [KNOB_W-1:0]        knob_shape_a;
	logic signed [JACK_W-1:0] jack_shape_a;
	logic [KNOB_W-1:0]        knob_shape_b;
	logic signed [JACK_W-1:0] jack_shape_b;

	modport source (
		output valid, clock_trig_a, clock_trig_b, reset_pulse, led_select,
		output knob_rate_a, jack_rate_a, knob_rate_b, jack_rate_b,
		output knob_shape_a, jack_shape_a, knob_shape_b, jack_shape_b,
		input  ready
	);

	modport sink (
		input  valid, clock_trig_a, clock_trig_b, reset_pulse, led_select,
		input  knob_rate_a, jack_rate_a, knob_rate_b, jack_rate_b,
		input  knob_shape_a, jack_shape_a, knob_shape_b, jack_shape_b,
		output ready
	);
endinterface

interface cslfo_out_if #(
	parameter int OUTPUT_BITS = cslfo_pkg::OUTPUT_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [OUTPUT_BITS-1:0] lfo_a;
	logic signed [OUTPUT_BITS-1:0] lfo_b;
	logic signed [OUTPUT_BITS-1:0] led_level;

	modport source (output valid, lfo_a, lfo_b, led_level, input ready);
	modport sink (input valid, lfo_a, lfo_b, led_level, output ready);
endinterface

`default_nettype wire

### src/clock_synced_dual_lfo_unit.sv
// clock_synced_dual_lfo_unit: clock-synced lfos a and b under a shared sequencer
// an lfo that is triggered with a nonzero tick count runs the shared
// restoring divider (DVD_W = 32 + clog2(MAX_MULTIPLIER+1) bits wide);
// lfo a is worked first, then lfo b; a new transaction is accepted only in
// idle, after the last result has been loaded into the result register
// reset: phases 0, increments 429497, tick counts 0, no result pending
`default_nettype none

module clock_synced_dual_lfo_unit #(
	parameter int SINE_TABLE_DEPTH = cslfo_pkg::SINE_TABLE_DEPTH_DEF,
	parameter int OUTPUT_BITS      = cslfo_pkg::OUTPUT_BITS_DEF,
	parameter int MAX_MULTIPLIER   = cslfo_pkg::MAX_MULTIPLIER_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	cslfo_in_if.sink        item,
	cslfo_out_if.source     result
);
	import cslfo_pkg::*;

	localparam int FRAC     = OUTPUT_BITS - 1;
	localparam int IDX_W    = $clog2(SINE_TABLE_DEPTH);
	localparam int IPROD_W  = PHASE_W + $clog2(SINE_TABLE_DEPTH + 1);
	localparam int MW       = $clog2(MAX_MULTIPLIER + 1);
	localparam int MPROD_W  = CTL_W + MW;
	localparam int DVD_W    = PHASE_W + MW;
	localparam int DCNT_W   = $clog2(DVD_W + 1);

	// ------------------------------------------------------------------
	// cosine table, worked out at elaboration, read through a register
	// ------------------------------------------------------------------
	logic [OUTPUT_BITS-1:0] cos_rom [SINE_TABLE_DEPTH];

	for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam longint D    = SINE_TABLE_DEPTH;
		localparam longint M    = (2 * k > D) ? D - k : k;
		localparam longint X0   = (2 * PI_Q30 * M) / D;
		localparam bit     NEG  = (4 * M > D);
		localparam longint X    = NEG ? PI_Q30 - X0 : X0;
		localparam longint C0   = cos_q30(64'(X));
		localparam longint C1   = (C0 > ONE_Q30) ? ONE_Q30 : ((C0 < 0) ? 0 : C0);
		localparam longint HALF = NEG ? ONE_Q30 - C1 : ONE_Q30 + C1;
		localparam longint ENT  = (HALF + (longint'(1) << (30 - FRAC))) >>> (31 - FRAC);
		assign cos_rom[k] = OUTPUT_BITS'(ENT);
	end

	// ------------------------------------------------------------------
	// latched tick transaction
	// ------------------------------------------------------------------
	logic                     trig_a_q, trig_b_q, rst_pulse_q, led_sel_q;
	logic [KNOB_W-1:0]        knob_rate_a_q, knob_rate_b_q, knob_shape_a_q, knob_shape_b_q;
	logic signed [JACK_W-1:0] jack_rate_a_q, jack_rate_b_q, jack_shape_a_q, jack_shape_b_q;

	// per-tick controls
	logic [MW-1:0] mult_a_q, mult_b_q;
	shape_t        shape_a_q, shape_b_q;

	// lfo state
	logic [PHASE_W-1:0] phase_a_q, phase_b_q;
	logic [PHASE_W-1:0] inc_a_q, inc_b_q;
	logic [PHASE_W-1:0] count_a_q, count_b_q;

	// sequencer
	state_t state_q, state_d;
	logic   sel_q;          // 0 works on lfo a, 1 on lfo b

	// divider
	logic [PHASE_W-1:0] div_rem_q;
	logic [DVD_W-1:0]   div_dvd_q;
	logic [PHASE_W-1:0] div_den_q;
	logic [DCNT_W-1:0]  div_cnt_q;

	// table index and shaped values
	logic [IDX_W-1:0]              idx_q;
	logic [OUTPUT_BITS-1:0]        rom_q;
	logic signed [OUTPUT_BITS-1:0] val_a_q, val_b_q;

	// result register
	logic                          res_valid_q;
	logic signed [OUTPUT_BITS-1:0] res_a_q, res_b_q, res_led_q;

	// control strobes from the sequencer
	logic item_ready, prep_en, div_load, div_step, inc_write;
	logic upd_en, idx_en, rom_en, shape_en, res_load;

	// ------------------------------------------------------------------
	// currently selected lfo
	// ------------------------------------------------------------------
	logic               cur_trig;
	logic [PHASE_W-1:0] cur_count, cur_phase, cur_inc;
	logic [MW-1:0]      cur_mult;
	shape_t             cur_shape;
	logic               div_needed;
	logic               div_last;

	assign cur_trig   = sel_q ? trig_b_q : trig_a_q;
	assign cur_count  = sel_q ? count_b_q : count_a_q;
	assign cur_phase  = sel_q ? phase_b_q : phase_a_q;
	assign cur_inc    = sel_q ? inc_b_q : inc_a_q;
	assign cur_mult   = sel_q ? mult_b_q : mult_a_q;
	assign cur_shape  = sel_q ? shape_b_q : shape_a_q;
	// a trigger on a zero count keeps the old increment
	assign div_needed = cur_trig && (cur_count != '0);
	assign div_last   = (div_cnt_q == DCNT_W'(DVD_W - 1));

	// ------------------------------------------------------------------
	// sequencer: next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:      if (item.valid) state_d = ST_PREP;
			ST_PREP:      state_d = ST_DIV_START;
			ST_DIV_START: state_d = div_needed ? ST_DIV : ST_UPDATE;
			ST_DIV:       if (div_last) state_d = ST_DIV_END;
			ST_DIV_END:   state_d = ST_UPDATE;
			ST_UPDATE:    state_d = ST_INDEX;
			ST_INDEX:     state_d = ST_ROM;
			ST_ROM:       state_d = ST_SHAPE;
			ST_SHAPE:     state_d = sel_q ? ST_FIN : ST_DIV_START;
			ST_FIN:       if (!res_valid_q || result.ready) state_d = ST_IDLE;
			default:      state_d = ST_IDLE;
		endcase
	end

	// ------------------------------------------------------------------
	// sequencer: strobes
	// ------------------------------------------------------------------
	always_comb begin
		item_ready = 1'b0;
		prep_en    = 1'b0;
		div_load   = 1'b0;
		div_step   = 1'b0;
		inc_write  = 1'b0;
		upd_en     = 1'b0;
		idx_en     = 1'b0;
		rom_en     = 1'b0;
		shape_en   = 1'b0;
		res_load   = 1'b0;
		unique case (state_q)
			ST_IDLE:      item_ready = 1'b1;
			ST_PREP:      prep_en    = 1'b1;
			ST_DIV_START: div_load   = div_needed;
			ST_DIV:       div_step   = 1'b1;
			ST_DIV_END:   inc_write  = 1'b1;
			ST_UPDATE:    upd_en     = 1'b1;
			ST_INDEX:     idx_en     = 1'b1;
			ST_ROM:       rom_en     = 1'b1;
			ST_SHAPE:     shape_en   = 1'b1;
			ST_FIN:       res_load   = !res_valid_q || result.ready;
			default:      item_ready = 1'b0;
		endcase
	end

	assign item.ready = item_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sel_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (prep_en) begin
				sel_q <= 1'b0;
			end else if (shape_en) begin
				sel_q <= ~sel_q;
			end
		end
	end

	// ------------------------------------------------------------------
	// input transaction capture
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (item.valid && item_ready) begin
			trig_a_q       <= item.clock_trig_a;
			trig_b_q       <= item.clock_trig_b;
			rst_pulse_q    <= item.reset_pulse;
			led_sel_q      <= item.led_select;
			knob_rate_a_q  <= item.knob_rate_a;
			jack_rate_a_q  <= item.jack_rate_a;
			knob_rate_b_q  <= item.knob_rate_b;
			jack_rate_b_q  <= item.jack_rate_b;
			knob_shape_a_q <= item.knob_shape_a;
			jack_shape_a_q <= item.jack_shape_a;
			knob_shape_b_q <= item.knob_shape_b;
			jack_shape_b_q <= item.jack_shape_b;
		end
	end

	// ------------------------------------------------------------------
	// controls: multiplier 1..MAX_MULTIPLIER and shape 0..4
	// ------------------------------------------------------------------
	logic [CTL_W-1:0]      rate_t_a, rate_t_b, shape_t_a, shape_t_b;
	logic [MPROD_W-1:0]    mprod_a, mprod_b;
	logic [SHP_PROD_W-1:0] sprod_a, sprod_b;
	shape_t                shape_a_d, shape_b_d;

	assign rate_t_a  = control_t(knob_rate_a_q, jack_rate_a_q);
	assign rate_t_b  = control_t(knob_rate_b_q, jack_rate_b_q);
	assign shape_t_a = control_t(knob_shape_a_q, jack_shape_a_q);
	assign shape_t_b = control_t(knob_shape_b_q, jack_shape_b_q);

	assign mprod_a = MPROD_W'(rate_t_a) * MPROD_W'(MAX_MULTIPLIER - 1);
	assign mprod_b = MPROD_W'(rate_t_b) * MPROD_W'(MAX_MULTIPLIER - 1);
	assign sprod_a = SHP_PROD_W'(shape_t_a) * SHP_MUL;
	assign sprod_b = SHP_PROD_W'(shape_t_b) * SHP_MUL;

	function automatic shape_t shape_of(input logic [SHP_PROD_W-1:0] p);
		if (p >= SHP_TH4)      return SHP_RAMP;
		else if (p >= SHP_TH3) return SHP_COSINE;
		else if (p >= SHP_TH2) return SHP_SQUARE;
		else if (p >= SHP_TH1) return SHP_REV_RAMP;
		else                   return SHP_TRIANGLE;
	endfunction

	assign shape_a_d = shape_of(sprod_a);
	assign shape_b_d = shape_of(sprod_b);

	always_ff @(posedge clk) begin
		if (prep_en) begin
			mult_a_q  <= MW'(mprod_a >> 12) + MW'(1);
			mult_b_q  <= MW'(mprod_b >> 12) + MW'(1);
			shape_a_q <= shape_a_d;
			shape_b_q <= shape_b_d;
		end
	end

	// ------------------------------------------------------------------
	// shared restoring divider: (mult << 32) / count, one bit per cycle
	// ------------------------------------------------------------------
	logic [PHASE_W:0] rem_sh, rem_sub;
	logic             rem_ge;

	assign rem_sh  = {div_rem_q, div_dvd_q[DVD_W-1]};
	assign rem_ge  = rem_sh >= {1'b0, div_den_q};
	assign rem_sub = rem_sh - {1'b0, div_den_q};

	always_ff @(posedge clk) begin
		if (div_load) begin
			div_rem_q <= '0;
			div_dvd_q <= {cur_mult, {PHASE_W{1'b0}}};
			div_den_q <= cur_count;
			div_cnt_q <= '0;
		end else if (div_step) begin
			div_rem_q <= rem_ge ? rem_sub[PHASE_W-1:0] : rem_sh[PHASE_W-1:0];
			div_dvd_q <= {div_dvd_q[DVD_W-2:0], rem_ge};
			div_cnt_q <= div_cnt_q + DCNT_W'(1);
		end
	end

	// ------------------------------------------------------------------
	// lfo state update: increment, count and phase of the selected lfo
	// ------------------------------------------------------------------
	logic [PHASE_W-1:0] phase_base, phase_next, count_next;

	// a reset pulse or a trigger restarts the phase before the step
	assign phase_base = (rst_pulse_q || cur_trig) ? '0 : cur_phase;
	assign phase_next = phase_base + cur_inc;
	assign count_next = cur_trig ? PHASE_W'(1)
			: ((cur_count == COUNT_MAX) ? COUNT_MAX : cur_count + PHASE_W'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_a_q <= '0;
			phase_b_q <= '0;
			inc_a_q   <= INC_RESET;
			inc_b_q   <= INC_RESET;
			count_a_q <= '0;
			count_b_q <= '0;
		end else begin
			if (inc_write) begin
				if (sel_q) inc_b_q <= div_dvd_q[PHASE_W-1:0];
				else       inc_a_q <= div_dvd_q[PHASE_W-1:0];
			end
			if (upd_en) begin
				if (sel_q) begin
					phase_b_q <= phase_next;
					count_b_q <= count_next;
				end else begin
					phase_a_q <= phase_next;
					count_a_q <= count_next;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// table index floor(p*D/2^32), registered table read
	// ------------------------------------------------------------------
	logic [IPROD_W-1:0] iprod;

	assign iprod = IPROD_W'(cur_phase) * IPROD_W'(SINE_TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (idx_en) idx_q <= iprod[PHASE_W +: IDX_W];
		if (rom_en) rom_q <= cos_rom[idx_q];
	end

	// ------------------------------------------------------------------
	// waveform shaping and negation
	// ------------------------------------------------------------------
	logic [PHASE_W:0]       p_ext, p_inv;
	logic [OUTPUT_BITS-1:0] shape_val;

	assign p_ext = {1'b0, cur_phase};
	assign p_inv = {1'b1, {PHASE_W{1'b0}}} - p_ext;

	always_comb begin
		case (cur_shape)
			SHP_TRIANGLE: shape_val = OUTPUT_BITS'((cur_phase[PHASE_W-1] ? p_inv : p_ext)
					>> (31 - FRAC));
			SHP_REV_RAMP: shape_val = OUTPUT_BITS'(p_inv >> (32 - FRAC));
			SHP_SQUARE:   shape_val = cur_phase[PHASE_W-1] ? '0
					: OUTPUT_BITS'(1) << FRAC;
			SHP_COSINE:   shape_val = rom_q;
			SHP_RAMP:     shape_val = OUTPUT_BITS'(p_ext >> (32 - FRAC));
			default:      shape_val = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (shape_en) begin
			if (sel_q) val_b_q <= $signed(OUTPUT_BITS'(0) - shape_val);
			else       val_a_q <= $signed(OUTPUT_BITS'(0) - shape_val);
		end
	end

	// ------------------------------------------------------------------
	// result register: holds a finished transaction until taken
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (res_load) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			res_a_q   <= val_a_q;
			res_b_q   <= val_b_q;
			res_led_q <= led_sel_q ? val_b_q : val_a_q;
		end
	end

	assign result.valid     = res_valid_q;
	assign result.lfo_a     = res_a_q;
	assign result.lfo_b     = res_b_q;
	assign result.led_level = res_led_q;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	// an accepted transaction starts the control preparation next cycle
	a_accept_prep: assert property (@(posedge clk) disable iff (!arst_n)
		item.valid && item.ready |=> state_q == ST_PREP)
		else $error("accepted transaction did not start the sequencer");

	// the divider never runs on a zero tick count
	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_den_q != '0)
		else $error("divider running with zero divisor");

	// the divider never runs past its last step
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV |-> div_cnt_q < DCNT_W'(DVD_W))
		else $error("divider step count overran");

	// the table index stays inside the table
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_ROM |-> 32'(idx_q) < 32'(SINE_TABLE_DEPTH))
		else $error("cosine table index out of range");

	// a new result only appears after both lfos were shaped
	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q) == ST_FIN)
		else $error("result raised outside the final step");

endmodule

`default_nettype wire
